/* design/sorted_unique_set_assert.svh */
// Assertion helpers for the sorted set block.
`ifndef SORTED_UNIQUE_SET_ASSERT_SVH
`define SORTED_UNIQUE_SET_ASSERT_SVH

// Clocked check, off while reset is asserted.
`define SUS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge.
`define SUS_ASSERT_NEVER(lbl, cond, msg) \
    `SUS_ASSERT(lbl, !(cond), msg)

`endif

/* design/sus_pkg.sv */
package sus_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int OP_W          = 2;
    localparam int VALUE_W       = 32;
    localparam int STATUS_W      = 2;
    localparam int COUNT_W       = 7;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_DUP       = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

endpackage

/* design/sus_ram.sv */
module sus_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/sorted_unique_set.sv */
// Channel  | Handshake             | Payload
// ---------+-----------------------+--------------------------------------
// request  | req_valid / req_stall | op [1:0], value [31:0] signed
// response | rsp_valid / rsp_stall | status [1:0], entry_count [6:0]
//
// A transaction runs from acceptance to result as a pipelined ascending scan
// of the single-read, single-write entry RAM that moves entries by one slot
// on insert or remove, then a result state; the scan stops early once the
// outcome is known and nothing has to move.
// req_stall is high from acceptance until the result is loaded; no new
// request is taken before then.
// Reset clears the entry count; a stalled response holds the result state.
module sorted_unique_set #(
    parameter int DEPTH = sus_pkg::DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [sus_pkg::OP_W-1:0]      op,
    input  logic signed [sus_pkg::VALUE_W-1:0] value,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [sus_pkg::STATUS_W-1:0]  status,
    output logic [sus_pkg::COUNT_W-1:0]   entry_count
);

    import sus_pkg::*;

    `include "sorted_unique_set_assert.svh"

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [VALUE_W-1:0]   val_reg, val_next;
    logic [VALUE_W-1:0]   carry_reg, carry_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [CW-1:0]        ra_reg, ra_next;
    logic [AW-1:0]        di_reg, di_next;
    logic                 dv_reg, dv_next;
    logic                 shift_reg, shift_next;
    status_t              st_reg, st_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [COUNT_W-1:0]   count_reg, count_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [VALUE_W-1:0]   ram_wdata;
    logic [VALUE_W-1:0]   ram_rdata;
    logic                 issue;
    logic                 full;

    sus_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ra_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign full        = (cnt_reg == CW'(DEPTH));
    assign req_stall   = (state_reg != S_IDLE);
    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign entry_count = count_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        carry_next     = carry_reg;
        cnt_next       = cnt_reg;
        ra_next        = ra_reg;
        di_next        = di_reg;
        dv_next        = dv_reg;
        shift_next     = shift_reg;
        st_next        = st_reg;
        status_next    = status_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        ram_we         = 1'b0;
        ram_waddr      = di_reg;
        ram_wdata      = carry_reg;
        issue          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && !req_stall)
                begin
                    op_next    = op;
                    val_next   = value;
                    ra_next    = '0;
                    dv_next    = 1'b0;
                    shift_next = 1'b0;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                issue   = (ra_reg < cnt_reg);
                dv_next = issue;
                di_next = ra_reg[AW-1:0];
                ra_next = ra_reg + CW'(issue);
                if (dv_reg)
                begin
                    if (!shift_reg)
                    begin
                        if ($signed(ram_rdata) >= $signed(val_reg))
                        begin
                            if (ram_rdata == val_reg)
                            begin
                                case (op_reg)
                                    OP_INSERT:
                                    begin
                                        st_next    = ST_DUP;
                                        state_next = S_DONE;
                                    end
                                    OP_REMOVE:
                                    begin
                                        shift_next = 1'b1;
                                    end
                                    default:
                                    begin
                                        st_next    = ST_OK;
                                        state_next = S_DONE;
                                    end
                                endcase
                            end
                            else
                            begin
                                case (op_reg)
                                    OP_INSERT:
                                    begin
                                        if (full)
                                        begin
                                            st_next    = ST_FULL;
                                            state_next = S_DONE;
                                        end
                                        else
                                        begin
                                            ram_we     = 1'b1;
                                            ram_waddr  = di_reg;
                                            ram_wdata  = val_reg;
                                            carry_next = ram_rdata;
                                            shift_next = 1'b1;
                                        end
                                    end
                                    default:
                                    begin
                                        st_next    = ST_NOT_FOUND;
                                        state_next = S_DONE;
                                    end
                                endcase
                            end
                        end
                    end
                    else if (op_reg == OP_INSERT)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = di_reg;
                        ram_wdata  = carry_reg;
                        carry_next = ram_rdata;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = di_reg - AW'(1);
                        ram_wdata = ram_rdata;
                    end
                end
                else if (ra_reg == cnt_reg)
                begin
                    // end of held entries
                    state_next = S_DONE;
                    case (op_reg)
                        OP_INSERT:
                        begin
                            if (!shift_reg && full)
                            begin
                                st_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = cnt_reg[AW-1:0];
                                ram_wdata = shift_reg ? carry_reg : val_reg;
                                cnt_next  = cnt_reg + CW'(1);
                                st_next   = ST_OK;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (shift_reg)
                            begin
                                cnt_next = cnt_reg - CW'(1);
                                st_next  = ST_OK;
                            end
                            else
                            begin
                                st_next = ST_NOT_FOUND;
                            end
                        end
                        default:
                        begin
                            st_next = ST_NOT_FOUND;
                        end
                    endcase
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = st_reg;
                    count_next     = COUNT_W'(cnt_reg);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= '0;
            val_reg       <= '0;
            carry_reg     <= '0;
            cnt_reg       <= '0;
            ra_reg        <= '0;
            di_reg        <= '0;
            dv_reg        <= 1'b0;
            shift_reg     <= 1'b0;
            st_reg        <= ST_OK;
            rsp_valid_reg <= 1'b0;
            status_reg    <= '0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            val_reg       <= val_next;
            carry_reg     <= carry_next;
            cnt_reg       <= cnt_next;
            ra_reg        <= ra_next;
            di_reg        <= di_next;
            dv_reg        <= dv_next;
            shift_reg     <= shift_next;
            st_reg        <= st_next;
            rsp_valid_reg <= rsp_valid_next;
            status_reg    <= status_next;
            count_reg     <= count_next;
        end
    end

    `SUS_ASSERT_NEVER(a_cnt_bound, cnt_reg > CW'(DEPTH), "entry count above depth")
    `SUS_ASSERT(a_cnt_scan_only, (state_reg != S_SCAN) |=> $stable(cnt_reg),
                "entry count changed outside scan")
    `SUS_ASSERT(a_write_scan_only, ram_we |-> (state_reg == S_SCAN), "RAM write outside scan")

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;
    import sus_pkg::*;

    localparam int SET_DEPTH = DEPTH_DEFAULT;
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam int POOL_SIZE = 96;

    typedef struct {
        status_t              st;
        logic [COUNT_W-1:0]   cnt;
    } set_reply_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    logic [OP_W-1:0] op = OP_INSERT;
    logic signed [VALUE_W-1:0] value = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0] entry_count;

    logic signed [VALUE_W-1:0] mirror_set[$];
    set_reply_t replies_due[$];
    logic signed [VALUE_W-1:0] value_pool[POOL_SIZE];

    bit calm = 1'b0;
    int hold_ask = 0;
    int hold_left = 0;
    int held_total = 0;
    int fail_count = 0;
    int checked_count = 0;
    int peak_size = 0;
    int status_tally[4];

    sorted_unique_set #(
        .DEPTH(SET_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .op(op),
        .value(value),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .status(status),
        .entry_count(entry_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Applies one operation to the mirror set and returns the reply it yields.
    function automatic set_reply_t apply_set_op(input logic [OP_W-1:0] code,
                                                input logic signed [VALUE_W-1:0] v);
        set_reply_t r;
        int pos;
        bit present;
        pos = 0;
        while (pos < mirror_set.size() && mirror_set[pos] < v)
            pos++;
        present = (pos < mirror_set.size()) && (mirror_set[pos] == v);
        case (code)
            OP_INSERT:
            begin
                if (present)
                    r.st = ST_DUP;
                else if (mirror_set.size() >= SET_DEPTH)
                    r.st = ST_FULL;
                else
                begin
                    mirror_set.insert(pos, v);
                    r.st = ST_OK;
                end
            end
            OP_REMOVE:
            begin
                if (!present)
                    r.st = ST_NOT_FOUND;
                else
                begin
                    mirror_set.delete(pos);
                    r.st = ST_OK;
                end
            end
            default:
                r.st = present ? ST_OK : ST_NOT_FOUND;
        endcase
        r.cnt = COUNT_W'(mirror_set.size());
        return r;
    endfunction

    task automatic send_item(input logic [OP_W-1:0] code,
                             input logic signed [VALUE_W-1:0] v);
        set_reply_t r;
        req_valid <= 1'b1;
        op <= code;
        value <= v;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        r = apply_set_op(code, v);
        replies_due.push_back(r);
        status_tally[r.st]++;
        if (mirror_set.size() > peak_size)
            peak_size = mirror_set.size();
        if (!calm && $urandom_range(0, 99) < 13)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 99) < 75)
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int w;
        w = $urandom_range(0, 99);
        if (w < 40)
            return OP_INSERT;
        if (w < 70)
            return OP_REMOVE;
        if (w < 90)
            return OP_LOOKUP;
        return OP_SPARE;
    endfunction

    task automatic test_directed();
        send_item(OP_LOOKUP, 0);
        send_item(OP_REMOVE, 7);
        send_item(OP_SPARE, 0);
        send_item(OP_INSERT, 0);
        send_item(OP_INSERT, VAL_MIN);
        send_item(OP_INSERT, VAL_MAX);
        send_item(OP_INSERT, -1);
        send_item(OP_INSERT, 1);
        send_item(OP_INSERT, VAL_MAX);
        send_item(OP_INSERT, VAL_MIN);
        send_item(OP_LOOKUP, VAL_MIN);
        send_item(OP_LOOKUP, VAL_MAX);
        send_item(OP_LOOKUP, 2);
        send_item(OP_SPARE, -1);
        send_item(OP_REMOVE, 0);
        send_item(OP_REMOVE, VAL_MIN);
        send_item(OP_REMOVE, VAL_MAX);
        send_item(OP_REMOVE, VAL_MAX);
        send_item(OP_LOOKUP, VAL_MAX);
        send_item(OP_REMOVE, -1);
        send_item(OP_REMOVE, 1);
        send_item(OP_INSERT, 32'sh5555_5555);
        send_item(OP_INSERT, 32'shAAAA_AAAA);
    endtask

    task automatic test_random_mix(input int n);
        repeat (n) send_item(pick_op(), pick_value());
    endtask

    // Fill to capacity, probe full and duplicate handling, then drain.
    task automatic test_fill_drain();
        logic signed [VALUE_W-1:0] v;
        while (mirror_set.size() < SET_DEPTH)
            send_item(OP_INSERT, pick_value());
        repeat (4) send_item(OP_INSERT, $urandom);
        repeat (3) send_item(OP_INSERT, mirror_set[$urandom_range(0, SET_DEPTH - 1)]);
        send_item(OP_LOOKUP, mirror_set[0]);
        send_item(OP_SPARE, mirror_set[SET_DEPTH - 1]);
        send_item(OP_REMOVE, mirror_set[$urandom_range(0, SET_DEPTH - 1)]);
        send_item(OP_INSERT, VAL_MAX);
        send_item(OP_INSERT, VAL_MIN);
        while (mirror_set.size() > 0)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                v = mirror_set[$urandom_range(0, mirror_set.size() - 1)];
                send_item(OP_REMOVE, v);
            end
            else
                send_item(pick_op(), pick_value());
        end
    endtask

    // Receiver holds off while the sender keeps offering transactions.
    task automatic test_backpressure();
        hold_ask = 300;
        repeat (24) send_item(pick_op(), pick_value());
    endtask

    task automatic test_no_idle(input int n);
        calm = 1'b1;
        test_random_mix(n);
        calm = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left--;
            held_total++;
        end
        else if (hold_ask > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left = hold_ask - 1;
            hold_ask = 0;
            held_total++;
        end
        else
            rsp_stall <= !calm && ($urandom_range(0, 99) < 13);
    end

    always @(posedge clk)
    begin
        set_reply_t e;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (replies_due.size() == 0)
            begin
                $error("unexpected transaction: status %0d entry_count %0d",
                       status, entry_count);
                fail_count++;
            end
            else
            begin
                e = replies_due.pop_front();
                checked_count++;
                if (status !== e.st)
                begin
                    $error("status: expected %0d, got %0d", e.st, status);
                    fail_count++;
                end
                if (entry_count !== e.cnt)
                begin
                    $error("entry_count: expected %0d, got %0d", e.cnt, entry_count);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        value_pool[0] = VAL_MIN;
        value_pool[1] = VAL_MAX;
        value_pool[2] = 0;
        value_pool[3] = -1;
        for (int i = 4; i < POOL_SIZE; i++)
            value_pool[i] = ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 200) - 100;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_mix(450);
        test_fill_drain();
        test_backpressure();
        test_no_idle(300);
        test_random_mix(300);

        req_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (SET_DEPTH + 8) @(posedge clk);

        $display("tb: %0d transactions checked; ok %0d, duplicate %0d, not found %0d, full %0d",
                 checked_count, status_tally[ST_OK], status_tally[ST_DUP],
                 status_tally[ST_NOT_FOUND], status_tally[ST_FULL]);
        $display("tb: set peaked at %0d entries; receiver held off %0d cycles",
                 peak_size, held_total);
        if (fail_count == 0 && replies_due.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/sus_pkg.sv
design/sus_ram.sv
design/sorted_unique_set.sv
bench/tb.sv
